[src/assert_macros.svh]
// Assertion macros shared by the converter's RTL files.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/hsv_pkg.sv]
// Shared widths, constants, stage map and types for the RGB to HSV converter.
// Used by every module of the block; depends on nothing.
package hsv_pkg;

  // Field widths.
  localparam int CH_W   = 8;   // colour channel
  localparam int HUE_W  = 9;   // hue in degrees
  localparam int PCT_W  = 7;   // percentages
  localparam int QUO_W  = 16;  // wide quotient of the hue divisions
  localparam int PROD_W = 23;  // mid * 25500
  localparam int Y_W    = 15;  // 255 * (100 - s)
  localparam int T_W    = 6;   // hue offset inside a sextant, 0..60

  // Scale constants.
  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [T_W-1:0]   SEXT_DEG   = 6'd60;
  localparam logic [HUE_W:0]   HUE_WRAP   = 10'd360;
  localparam logic [Y_W-1:0]   HUE_SCALE  = 15'd25500;
  localparam logic [QUO_W-1:0] CH_MAX     = 16'd255;

  // Sextant bases in degrees.
  localparam logic [HUE_W-1:0] BASE_RED_GRN  = 9'd0;
  localparam logic [HUE_W-1:0] BASE_GRN_RED  = 9'd60;
  localparam logic [HUE_W-1:0] BASE_GRN_BLU  = 9'd120;
  localparam logic [HUE_W-1:0] BASE_BLU_GRN  = 9'd180;
  localparam logic [HUE_W-1:0] BASE_BLU_RED  = 9'd240;
  localparam logic [HUE_W-1:0] BASE_RED_BLU  = 9'd300;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEPS = 2;

  // Pipeline stage map.
  localparam int ST_SORT    = 0;
  localparam int ST_PREP    = 1;
  localparam int ST_DIV_A   = 2;
  localparam int ST_SAT     = ST_DIV_A + CH_W / DIV_STEPS;
  localparam int ST_SCALE   = ST_SAT + 1;
  localparam int ST_DIFF    = ST_DIV_A + QUO_W / DIV_STEPS;
  localparam int ST_DIV3    = ST_DIFF + 1;
  localparam int ST_HUE_T   = ST_DIV3 + QUO_W / DIV_STEPS;
  localparam int ST_OUT     = ST_HUE_T + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // Result of the channel sort.
  typedef struct packed {
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  md;
    logic [CH_W-1:0]  mn;
    logic [HUE_W-1:0] base;
    logic             rev;
  } hsv_sort_t;

  // Per-pixel data that rides alongside the dividers.
  typedef struct packed {
    logic [HUE_W-1:0] base;
    logic             rev;
    logic             grey;
    logic             flat;
    logic [CH_W-1:0]  mx;
    logic [PCT_W-1:0] v;
    logic [PCT_W-1:0] s;
    logic [Y_W-1:0]   y;
  } hsv_side_t;

  // Stage controls from the pipeline controller.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } hsv_pipe_t;

  // Floor of n / 255 without a divider; exact for n up to 65534.
  function automatic logic [8:0] div255(input logic [15:0] n);
    logic [16:0] sum;
    sum = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
    return sum[16:8];
  endfunction

  // 100 * c for an 8-bit value, as shifts and adds.
  function automatic logic [15:0] times100(input logic [CH_W-1:0] c);
    return {2'b00, c, 6'd0} + {3'b000, c, 5'd0} + {6'd0, c, 2'd0};
  endfunction

endpackage

[src/hsv_sort.sv]
// Stage 0 of the converter: orders the channels and picks the sextant.
// Depends on hsv_pkg and assert_macros.svh.
module hsv_sort (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [hsv_pkg::CH_W-1:0] red,
  input  logic [hsv_pkg::CH_W-1:0] green,
  input  logic [hsv_pkg::CH_W-1:0] blue,
  output hsv_pkg::hsv_sort_t     sorted
);
  import hsv_pkg::*;

`include "assert_macros.svh"

  hsv_sort_t sort_r, sort_nxt;

  // Largest channel first, then the order of the other two.
  always_comb begin
    sort_nxt = '0;
    priority if (red >= green && red >= blue) begin
      sort_nxt.mx = red;
      if (blue > green) begin
        sort_nxt.base = BASE_RED_BLU;
        sort_nxt.md   = blue;
        sort_nxt.mn   = green;
        sort_nxt.rev  = 1'b1;
      end else begin
        sort_nxt.base = BASE_RED_GRN;
        sort_nxt.md   = green;
        sort_nxt.mn   = blue;
        sort_nxt.rev  = 1'b0;
      end
    end else if (green >= red && green >= blue) begin
      sort_nxt.mx = green;
      if (red > blue) begin
        sort_nxt.base = BASE_GRN_RED;
        sort_nxt.md   = red;
        sort_nxt.mn   = blue;
        sort_nxt.rev  = 1'b1;
      end else begin
        sort_nxt.base = BASE_GRN_BLU;
        sort_nxt.md   = blue;
        sort_nxt.mn   = red;
        sort_nxt.rev  = 1'b0;
      end
    end else begin
      sort_nxt.mx = blue;
      if (green > red) begin
        sort_nxt.base = BASE_BLU_GRN;
        sort_nxt.md   = green;
        sort_nxt.mn   = red;
        sort_nxt.rev  = 1'b1;
      end else begin
        sort_nxt.base = BASE_BLU_RED;
        sort_nxt.md   = red;
        sort_nxt.mn   = green;
        sort_nxt.rev  = 1'b0;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      sort_r <= sort_nxt;
    end
  end

  assign sorted = sort_r;

  // The sorted triple must be in descending order.
  `HSV_ASSERT_NXT(a_sort_order, en, sort_r.mx >= sort_r.md && sort_r.md >= sort_r.mn, "channel sort out of order")

endmodule

[src/hsv_div.sv]
// Pipelined restoring divider, two quotient bits per register stage.
// Depends on hsv_pkg. The high dividend part must be below the divisor.
module hsv_div #(
  parameter int LoW = hsv_pkg::QUO_W
) (
  input  logic                              clk,
  input  logic [LoW/hsv_pkg::DIV_STEPS-1:0] en,
  input  logic [hsv_pkg::CH_W-1:0]          num_hi,
  input  logic [LoW-1:0]                    num_lo,
  input  logic [hsv_pkg::CH_W-1:0]          den,
  output logic [LoW-1:0]                    quo
);
  import hsv_pkg::*;

  localparam int NumStg = LoW / DIV_STEPS;

  logic [CH_W-1:0] rem_r    [NumStg];
  logic [LoW-1:0]  work_r   [NumStg];
  logic [CH_W-1:0] den_r    [NumStg];
  logic [CH_W-1:0] rem_nxt  [NumStg];
  logic [LoW-1:0]  work_nxt [NumStg];
  logic [CH_W-1:0] den_nxt  [NumStg];

  // Each stage shifts in dividend bits and trial-subtracts the divisor.
  // Quotient bits enter the work word from the bottom as dividend bits leave the top.
  always_comb begin
    logic [CH_W-1:0] rem_v;
    logic [LoW-1:0]  work_v;
    logic [CH_W-1:0] den_v;
    logic [CH_W:0]   trial;
    logic            bit_v;
    for (int i = 0; i < NumStg; i++) begin
      if (i == 0) begin
        rem_v  = num_hi;
        work_v = num_lo;
        den_v  = den;
      end else begin
        rem_v  = rem_r[i-1];
        work_v = work_r[i-1];
        den_v  = den_r[i-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {rem_v, work_v[LoW-1]};
        if (trial >= {1'b0, den_v}) begin
          trial = trial - {1'b0, den_v};
          bit_v = 1'b1;
        end else begin
          bit_v = 1'b0;
        end
        rem_v  = trial[CH_W-1:0];
        work_v = {work_v[LoW-2:0], bit_v};
      end
      rem_nxt[i]  = rem_v;
      work_nxt[i] = work_v;
      den_nxt[i]  = den_v;
    end
  end

  // Stage registers, each loaded on its own enable.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumStg; i++) begin
      if (en[i]) begin
        rem_r[i]  <= rem_nxt[i];
        work_r[i] <= work_nxt[i];
        den_r[i]  <= den_nxt[i];
      end
    end
  end

  assign quo = work_r[NumStg-1];

endmodule

[src/hsv_ctrl.sv]
// Valid and load control for the converter pipeline, with bubble collapsing.
// Depends on hsv_pkg and assert_macros.svh.
module hsv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_stall,
  output logic               in_stall,
  output hsv_pkg::hsv_pipe_t pipe
);
  import hsv_pkg::*;

`include "assert_macros.svh"

  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] ready;

  // A stage may load when it is empty or when everything after it can move.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_ready
    assign ready[g] = !out_stall || !(&vld_r[NUM_STAGES-1:g]);
  end

  // Valid bits follow their data.
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (!ready[k]) begin
        vld_nxt[k] = vld_r[k];
      end else if (k == 0) begin
        vld_nxt[k] = in_valid;
      end else begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall   = !ready[0];
  assign pipe.load  = ready;
  assign pipe.valid = vld_r;

  // Without a beat on either side the number of pixels in flight is unchanged.
  `HSV_ASSERT_NXT(a_ctrl_conserve, !(in_valid && !in_stall) && !(vld_r[NUM_STAGES-1] && !out_stall), $countones(vld_r) == $past($countones(vld_r)), "pixel lost or duplicated in pipeline")
  // The input is held off only when every stage is occupied.
  `HSV_ASSERT_IMP(a_ctrl_full, in_stall, &vld_r, "input stalled while a stage is empty")

endmodule

[src/rgb_to_hsv_converter.sv]
// RGB to HSV converter top level. Throughput: one pixel per clock while out_stall is low;
// every stage, each divider step included, takes a new pixel.
// Dividers run as pipelines: min/max (4 stages), mid/max (8 stages), then term/sat (8 stages).
// Reset: rst_n is synchronous and active low; it clears only the stage valid bits.
// No clearing pass is needed, so the block takes pixels as soon as reset is released.
// Depends on hsv_pkg, hsv_sort, hsv_div, hsv_ctrl and assert_macros.svh.
module rgb_to_hsv_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [hsv_pkg::CH_W-1:0]  in_red,
  input  logic [hsv_pkg::CH_W-1:0]  in_green,
  input  logic [hsv_pkg::CH_W-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hsv_pkg::HUE_W-1:0] out_hue,
  output logic [hsv_pkg::PCT_W-1:0] out_saturation,
  output logic [hsv_pkg::PCT_W-1:0] out_brightness
);
  import hsv_pkg::*;

`include "assert_macros.svh"

  hsv_pipe_t pipe;
  hsv_sort_t sorted;

  hsv_side_t           side_r   [ST_PREP:ST_HUE_T];
  hsv_side_t           side_nxt [ST_PREP:ST_HUE_T];
  logic [PROD_W-1:0]   prod_r;
  logic [QUO_W-1:0]    minsc_r;
  logic [QUO_W-1:0]    term_r;
  logic [T_W-1:0]      toff_r;
  logic [CH_W-1:0]     scaled;
  logic [QUO_W-1:0]    xq;
  logic [QUO_W-1:0]    tq;
  logic [PCT_W-1:0]    diff;
  logic [15:0]         sat_num;
  logic [15:0]         toff_num;
  logic [T_W-1:0]      toff_full;
  logic [HUE_W:0]      hue_sum;
  logic [HUE_W-1:0]    hue_nxt;
  logic                out_in_range;

  // Pipeline control.
  hsv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .pipe      (pipe)
  );

  // Stage 0: channel sort.
  hsv_sort u_sort (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe.load[ST_SORT]),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .sorted (sorted)
  );

  // Stage 1: numerators for both divisions; brightness from the maximum.
  always_ff @(posedge clk) begin
    if (pipe.load[ST_PREP]) begin
      prod_r  <= PROD_W'({15'd0, sorted.md} * {8'd0, HUE_SCALE});
      minsc_r <= {sorted.mn, 8'd0} - {8'd0, sorted.mn};
    end
  end

  // min * 255 / max, giving the saturation ratio.
  hsv_div #(.LoW(CH_W)) u_div_sat (
    .clk    (clk),
    .en     (pipe.load[ST_DIV_A +: CH_W/DIV_STEPS]),
    .num_hi (minsc_r[QUO_W-1:CH_W]),
    .num_lo (minsc_r[CH_W-1:0]),
    .den    (side_r[ST_PREP].mx),
    .quo    (scaled)
  );

  // mid * 25500 / max.
  hsv_div #(.LoW(QUO_W)) u_div_mid (
    .clk    (clk),
    .en     (pipe.load[ST_DIV_A +: QUO_W/DIV_STEPS]),
    .num_hi ({1'b0, prod_r[PROD_W-1:QUO_W]}),
    .num_lo (prod_r[QUO_W-1:0]),
    .den    (side_r[ST_PREP].mx),
    .quo    (xq)
  );

  // Hue term divided by saturation.
  hsv_div #(.LoW(QUO_W)) u_div_hue (
    .clk    (clk),
    .en     (pipe.load[ST_DIV3 +: QUO_W/DIV_STEPS]),
    .num_hi ('0),
    .num_lo (term_r),
    .den    ({1'b0, side_r[ST_DIFF].s}),
    .quo    (tq)
  );

  // Saturation and its complement term.
  assign sat_num = times100(scaled);
  assign diff    = PCT_FULL - side_r[ST_SAT].s;

  // Side data moves stage by stage and is filled in where it becomes known.
  always_comb begin
    side_nxt[ST_PREP].base = sorted.base;
    side_nxt[ST_PREP].rev  = sorted.rev;
    side_nxt[ST_PREP].grey = (sorted.mx == sorted.mn);
    side_nxt[ST_PREP].flat = (sorted.md == sorted.mn);
    side_nxt[ST_PREP].mx   = sorted.mx;
    side_nxt[ST_PREP].v    = PCT_W'(div255(times100(sorted.mx)));
    side_nxt[ST_PREP].s    = '0;
    side_nxt[ST_PREP].y    = '0;
    for (int k = ST_PREP + 1; k <= ST_HUE_T; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    if (side_r[ST_SAT-1].grey) begin
      side_nxt[ST_SAT].s = '0;
    end else begin
      side_nxt[ST_SAT].s = PCT_FULL - PCT_W'(div255(sat_num));
    end
    side_nxt[ST_SCALE].y = {diff, 8'd0} - {8'd0, diff};
  end

  always_ff @(posedge clk) begin
    for (int k = ST_PREP; k <= ST_HUE_T; k++) begin
      if (pipe.load[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // Stage 10: hue term numerator, floored at zero.
  always_ff @(posedge clk) begin
    if (pipe.load[ST_DIFF]) begin
      if (xq > {1'b0, side_r[ST_DIFF-1].y}) begin
        term_r <= xq - {1'b0, side_r[ST_DIFF-1].y};
      end else begin
        term_r <= '0;
      end
    end
  end

  // Stage 19: scale to degrees by 60/255; a quotient of 255 or more saturates at 60.
  assign toff_num  = {2'b00, tq[CH_W-1:0], 6'd0} - {6'd0, tq[CH_W-1:0], 2'd0};
  assign toff_full = T_W'(div255(toff_num));

  always_ff @(posedge clk) begin
    if (pipe.load[ST_HUE_T]) begin
      if (tq >= CH_MAX) begin
        toff_r <= SEXT_DEG;
      end else begin
        toff_r <= toff_full;
      end
    end
  end

  // Final hue: base plus offset, or base + 60 minus offset in the reversed sextants.
  always_comb begin
    if (side_r[ST_HUE_T].rev) begin
      hue_sum = {1'b0, side_r[ST_HUE_T].base} + {4'd0, SEXT_DEG} - {4'd0, toff_r};
    end else begin
      hue_sum = {1'b0, side_r[ST_HUE_T].base} + {4'd0, toff_r};
    end
    if (side_r[ST_HUE_T].grey) begin
      hue_nxt = '0;
    end else if (side_r[ST_HUE_T].flat || side_r[ST_HUE_T].s == '0) begin
      hue_nxt = side_r[ST_HUE_T].base;
    end else if (hue_sum >= HUE_WRAP) begin
      hue_nxt = HUE_W'(hue_sum - HUE_WRAP);
    end else begin
      hue_nxt = hue_sum[HUE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (pipe.load[ST_OUT]) begin
      out_hue        <= hue_nxt;
      out_saturation <= side_r[ST_HUE_T].s;
      out_brightness <= side_r[ST_HUE_T].v;
    end
  end

  assign out_valid = pipe.valid[ST_OUT];

  // Range of the held result.
  assign out_in_range = ({1'b0, out_hue} < HUE_WRAP) && (out_saturation <= PCT_FULL) &&
                        (out_brightness <= PCT_FULL);

  // Every delivered pixel lies inside the HSV ranges.
  `HSV_ASSERT_IMP(a_top_range, out_valid, out_in_range, "HSV result out of range")

endmodule

[test/tb.sv]
// Self-checking testbench for rgb_to_hsv_converter: drives RGB pixel beats and checks
// every HSV result beat against an in-bench integer predictor.
// Depends on hsv_pkg and the converter RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv_pkg::*;

  localparam int RANDOM_PIXELS = 1050;
  // Idle mixes change as pixels are taken: sender light, then receiver light, then none.
  localparam int PHASE_A_END   = 360;
  localparam int PHASE_B_END   = 720;
  // One long receiver hold-off while the sender keeps offering pixels.
  localparam int HOLD_AT       = 850;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CH_W-1:0]  in_red = '0;
  logic [CH_W-1:0]  in_green = '0;
  logic [CH_W-1:0]  in_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HUE_W-1:0] out_hue;
  logic [PCT_W-1:0] out_saturation;
  logic [PCT_W-1:0] out_brightness;

  pixel_t      pixel_queue[$];
  hsv_t        expected_hsv[$];
  int unsigned pixels_total = 0;
  int unsigned pixels_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  logic        in_took = 1'b0;

  rgb_to_hsv_converter u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  always #5 clk = ~clk;

  // Integer HSV of one pixel, with every division truncating.
  function automatic hsv_t convert_pixel(pixel_t px);
    int unsigned r, g, b, hi, mid, lo, base, deg, sat, val, x, y, a, t;
    bit          reversed;
    hsv_t        res;
    r = 32'(px.red);
    g = 32'(px.green);
    b = 32'(px.blue);
    // The largest channel and the order of the other two pick the sextant.
    if (r >= g && r >= b) begin
      hi = r;
      if (b > g) begin
        base = 32'(BASE_RED_BLU); mid = b; lo = g; reversed = 1'b1;
      end else begin
        base = 32'(BASE_RED_GRN); mid = g; lo = b; reversed = 1'b0;
      end
    end else if (g >= r && g >= b) begin
      hi = g;
      if (r > b) begin
        base = 32'(BASE_GRN_RED); mid = r; lo = b; reversed = 1'b1;
      end else begin
        base = 32'(BASE_GRN_BLU); mid = b; lo = r; reversed = 1'b0;
      end
    end else begin
      hi = b;
      if (g > r) begin
        base = 32'(BASE_BLU_GRN); mid = g; lo = r; reversed = 1'b1;
      end else begin
        base = 32'(BASE_BLU_RED); mid = r; lo = g; reversed = 1'b0;
      end
    end
    val = (100 * hi) / 255;
    sat = (hi == 0 || hi == lo) ? 0 : 100 - (100 * ((lo * 255) / hi)) / 255;
    // Grey pixels have no hue; a flat middle channel sits on the sextant base.
    if (hi == lo) begin
      deg = 0;
    end else if (mid == lo || sat == 0) begin
      deg = base;
    end else begin
      x = (mid * 25500) / hi;
      y = 255 * (100 - sat);
      a = (x > y) ? x - y : 0;
      t = ((a / sat) * 60) / 255;
      if (t > 60) t = 60;
      deg = reversed ? base + 60 - t : base + t;
      if (deg >= 360) deg -= 360;
    end
    res.hue        = deg[HUE_W-1:0];
    res.saturation = sat[PCT_W-1:0];
    res.brightness = val[PCT_W-1:0];
    return res;
  endfunction

  task automatic add_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red   = r[CH_W-1:0];
    px.green = g[CH_W-1:0];
    px.blue  = b[CH_W-1:0];
    pixel_queue.push_back(px);
  endtask

  // A channel level a few steps either side of the given one, kept in range.
  function automatic logic [CH_W-1:0] jitter(input int level);
    int v;
    v = level + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  // Pixel driver: a new beat is offered only once the previous one has gone.
  always @(negedge clk) begin : pixel_driver
    pixel_t      next_px;
    bit          offer;
    int unsigned idle_pct;
    if (rst_n && (!in_valid || in_took)) begin
      idle_pct = (pixels_taken < PHASE_A_END) ? 15 : (pixels_taken < PHASE_B_END) ? 57 : 0;
      offer = pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct;
      if (offer) begin
        next_px  = pixel_queue.pop_front();
        in_red   <= next_px.red;
        in_green <= next_px.green;
        in_blue  <= next_px.blue;
      end
      in_valid <= offer;
    end
  end

  // Result back-pressure, with one long hold-off so that the pipeline fills up.
  always @(negedge clk) begin : result_stall
    int unsigned idle_pct;
    idle_pct = (pixels_taken < PHASE_A_END) ? 57 : (pixels_taken < PHASE_B_END) ? 15 : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_once && pixels_taken >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end
  end

  // Scoreboard: predict on each pixel beat, compare on each result beat.
  always @(posedge clk) begin : scoreboard
    hsv_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_hsv.push_back(convert_pixel({in_red, in_green, in_blue}));
      pixels_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hsv.size() == 0) begin
        $error("result beat with nothing expected: hue %0d sat %0d val %0d",
               out_hue, out_saturation, out_brightness);
        mismatch_count++;
      end else begin
        want = expected_hsv.pop_front();
        if (out_hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, out_hue);
          mismatch_count++;
        end
        if (out_saturation !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, out_saturation);
          mismatch_count++;
        end
        if (out_brightness !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness, out_brightness);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat while work is outstanding ends the run.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (rst_n && (pixels_taken < pixels_total || expected_hsv.size() > 0)) begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t      px;
    int unsigned kind;
    int          level;
    logic [CH_W-1:0] c1, c2;

    // Directed pixels: black, white, greys, primaries and each sextant.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 128, 0);
    add_pixel(128, 255, 0);
    add_pixel(0, 255, 128);
    add_pixel(0, 128, 255);
    add_pixel(128, 0, 255);
    add_pixel(255, 0, 128);
    // Ties between the two largest channels.
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    // Red-blue sextant whose hue lands on 360 and wraps to zero.
    add_pixel(255, 1, 2);
    // Smallest non-black maxima, a near-grey pixel, a near tie and mixed colours.
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 1);
    add_pixel(200, 199, 198);
    add_pixel(255, 254, 0);
    add_pixel(170, 85, 255);
    add_pixel(85, 170, 51);

    // Random pixels, weighted towards ties, greys and dark or saturated colours.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      kind = $urandom_range(99);
      c1 = 8'($urandom_range(255));
      c2 = 8'($urandom_range(255));
      if (kind < 45) begin
        px = {c1, c2, 8'($urandom_range(255))};
      end else if (kind < 65) begin
        level = int'($urandom_range(255));
        px = {jitter(level), jitter(level), jitter(level)};
      end else if (kind < 75) begin
        case ($urandom_range(2))
          0:       px = {c1, c1, c2};
          1:       px = {c1, c2, c1};
          default: px = {c2, c1, c1};
        endcase
      end else if (kind < 85) begin
        px = {8'($urandom_range(7)), 8'($urandom_range(7)), 8'($urandom_range(7))};
      end else if (kind < 90) begin
        px = {c1, c1, c1};
      end else begin
        case ($urandom_range(5))
          0:       px = {8'd255, 8'd0, c1};
          1:       px = {8'd255, c1, 8'd0};
          2:       px = {8'd0, 8'd255, c1};
          3:       px = {c1, 8'd255, 8'd0};
          4:       px = {8'd0, c1, 8'd255};
          default: px = {c1, 8'd0, 8'd255};
        endcase
      end
      pixel_queue.push_back(px);
    end
    pixels_total = pixel_queue.size();

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every pixel to be taken and every result to be checked, then drain.
    while (pixels_taken < pixels_total || expected_hsv.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_hsv.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
